// File: rtl/elpf_pkg.sv
// shared types and constants for the epsilon lexicase pool filter
// item and result structs, pool geometry and register reset value
// no dependencies
package elpf_pkg;

    localparam int POOL_SIZE     = 5;
    localparam int CASE_LIMIT    = 16;
    localparam int FITNESS_WIDTH = 32;
    localparam int EPS_WIDTH     = 16;
    localparam int FRAC_BITS     = 16;

    localparam int SLOT_W  = $clog2(POOL_SIZE);
    localparam int COUNT_W = $clog2(POOL_SIZE + 1);
    localparam int DEPTH_W = $clog2(CASE_LIMIT + 1);
    localparam int PROD_W  = FITNESS_WIDTH + EPS_WIDTH;

    localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(6554);
    localparam logic [POOL_SIZE-1:0] FULL_MASK = {POOL_SIZE{1'b1}};

    typedef struct packed {
        logic signed [FITNESS_WIDTH-1:0] fitness_0;
        logic signed [FITNESS_WIDTH-1:0] fitness_1;
        logic signed [FITNESS_WIDTH-1:0] fitness_2;
        logic signed [FITNESS_WIDTH-1:0] fitness_3;
        logic signed [FITNESS_WIDTH-1:0] fitness_4;
        logic                            first_case;
        logic                            last_case;
        logic [2:0]                      pick_rank;
    } elpf_item_t;

    typedef struct packed {
        logic [POOL_SIZE-1:0] alive_slots;
        logic [COUNT_W-1:0]   survivor_count;
        logic [DEPTH_W-1:0]   cases_used;
        logic [SLOT_W-1:0]    chosen_slot;
        logic                 choice_valid;
    } elpf_result_t;

    // selection state carried from one case to the next
    typedef struct packed {
        logic [POOL_SIZE-1:0] alive_mask;
        logic [DEPTH_W-1:0]   depth_count;
    } elpf_state_t;

endpackage

// File: rtl/elpf_filter.sv
// combinational filter for one test case: max over alive slots, tolerance
// from one multiply, slot drop, survivor count and rank pick
// depends on elpf_pkg
module elpf_filter
    import elpf_pkg::*;
(
    input  elpf_item_t             item,
    input  elpf_state_t            state,
    input  logic [EPS_WIDTH-1:0]   epsilon_fraction,
    output elpf_state_t            state_next,
    output elpf_result_t           result
);

    logic [FITNESS_WIDTH-1:0] fit_key [POOL_SIZE];
    logic [FITNESS_WIDTH-1:0] fit_raw [POOL_SIZE];
    logic [POOL_SIZE-1:0]     mask_in;
    logic [POOL_SIZE-1:0]     mask_out;
    logic [DEPTH_W-1:0]       depth_in;
    logic [DEPTH_W-1:0]       depth_out;
    logic [COUNT_W-1:0]       count_in;
    logic [COUNT_W-1:0]       count_out;
    logic [FITNESS_WIDTH-1:0] key_max;
    logic                     any_alive;
    logic [FITNESS_WIDTH-1:0] max_raw;
    logic [FITNESS_WIDTH-1:0] max_mag;
    logic [PROD_W-1:0]        product;
    logic [FITNESS_WIDTH-1:0] threshold;
    logic [FITNESS_WIDTH-1:0] gap;
    logic [COUNT_W-1:0]       seen;
    logic                     found;
    logic [SLOT_W-1:0]        chosen;

    assign fit_raw[0] = item.fitness_0;
    assign fit_raw[1] = item.fitness_1;
    assign fit_raw[2] = item.fitness_2;
    assign fit_raw[3] = item.fitness_3;
    assign fit_raw[4] = item.fitness_4;

    // offset-binary keys so unsigned compare gives signed order
    always_comb
    begin
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            fit_key[i] = fit_raw[i] ^ {1'b1, {(FITNESS_WIDTH-1){1'b0}}};
        end
    end

    assign mask_in  = item.first_case ? FULL_MASK : state.alive_mask;
    assign depth_in = item.first_case ? '0 : state.depth_count;

    always_comb
    begin
        count_in = '0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            count_in = count_in + COUNT_W'(mask_in[i]);
        end
    end

    always_comb
    begin
        key_max   = '0;
        any_alive = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (mask_in[i] && (!any_alive || fit_key[i] > key_max))
            begin
                key_max   = fit_key[i];
                any_alive = 1'b1;
            end
        end
    end

    assign max_raw   = key_max ^ {1'b1, {(FITNESS_WIDTH-1){1'b0}}};
    assign max_mag   = max_raw[FITNESS_WIDTH-1] ? (~max_raw + 1'b1) : max_raw;
    assign product   = PROD_W'(max_mag) * PROD_W'(epsilon_fraction);
    assign threshold = product[FRAC_BITS +: FITNESS_WIDTH];

    always_comb
    begin
        mask_out  = mask_in;
        depth_out = depth_in;
        gap       = '0;
        if (count_in > COUNT_W'(1))
        begin
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                gap = key_max - fit_key[i];
                if (mask_in[i] && gap > threshold)
                begin
                    mask_out[i] = 1'b0;
                end
            end
            if (depth_in < DEPTH_W'(CASE_LIMIT))
            begin
                depth_out = depth_in + 1'b1;
            end
        end
    end

    always_comb
    begin
        count_out = '0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            count_out = count_out + COUNT_W'(mask_out[i]);
        end
    end

    // rank pick in ascending slot order, saturating at the highest survivor
    always_comb
    begin
        seen   = '0;
        found  = 1'b0;
        chosen = '0;
        if (item.last_case)
        begin
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                if (mask_out[i] && !found)
                begin
                    chosen = SLOT_W'(i);
                    if (seen == COUNT_W'(item.pick_rank))
                    begin
                        found = 1'b1;
                    end
                    else
                    begin
                        seen = seen + 1'b1;
                    end
                end
            end
        end
    end

    assign state_next.alive_mask  = mask_out;
    assign state_next.depth_count = depth_out;

    assign result.alive_slots    = mask_out;
    assign result.survivor_count = count_out;
    assign result.cases_used     = depth_out;
    assign result.chosen_slot    = chosen;
    assign result.choice_valid   = item.last_case;

endmodule

// File: rtl/epsilon_lexicase_pool_filter.sv
// Epsilon lexicase pool filter. Accepts one test case per clock while in_stall is low and
// returns one result per case: the case lands in an input register, then the
// filter (alive-slot max, one 32x16 multiply for the tolerance, five compares and a rank
// pick) writes the result register and the alive mask in the same cycle. That alive-mask
// loop through the max, multiply and compare sets the clock period. A stalled result holds
// the input register, so the block keeps taking items until both registers are full.
// epsilon_fraction is written through the cfg channel, which is always ready.
// depends on elpf_pkg and elpf_filter
module epsilon_lexicase_pool_filter
    import elpf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [EPS_WIDTH-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  elpf_item_t           in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output elpf_result_t         out_item
);

    logic                 in_full_reg;
    logic                 in_full_next;
    elpf_item_t           in_item_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    elpf_result_t         out_item_reg;
    elpf_state_t          state_reg;
    elpf_state_t          state_next;
    logic [EPS_WIDTH-1:0] eps_reg;
    elpf_result_t         filt_result;
    logic                 advance;
    logic                 in_accept;

    elpf_filter u_filter (
        .item             (in_item_reg),
        .state            (state_reg),
        .epsilon_fraction (eps_reg),
        .state_next       (state_next),
        .result           (filt_result)
    );

    assign cfg_ready = 1'b1;
    assign advance   = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_accept)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg          <= 1'b0;
            out_valid_reg        <= 1'b0;
            state_reg.alive_mask <= FULL_MASK;
            state_reg.depth_count <= '0;
            eps_reg              <= EPS_RESET;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                eps_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= filt_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for epsilon_lexicase_pool_filter: directed and random selection events,
// a case-level predictor of the alive mask, case depth and rank pick, random idling on both sides
// depends on elpf_pkg and the filter rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import elpf_pkg::*;

    localparam int IDLE_PCT       = 21;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS    = 225;
    localparam int SETTLE_CYCLES  = 10;
    localparam longint FIT_MIN    = -(longint'(1) <<< 31);
    localparam longint FIT_MAX    = (longint'(1) <<< 31) - 1;

    typedef enum int {GEN_CLUSTER, GEN_TIES, GEN_RAW} gen_style_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [EPS_WIDTH-1:0] cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    elpf_item_t           in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    elpf_result_t         out_item;

    elpf_item_t   pending_cases[$];
    elpf_result_t pool_verdicts[$];
    elpf_result_t want;

    // predictor state
    logic [POOL_SIZE-1:0] pred_alive = FULL_MASK;
    int                   pred_depth = 0;
    logic [EPS_WIDTH-1:0] pred_eps   = EPS_RESET;

    int errors        = 0;
    bit quiet         = 1'b0;
    bit send_hold     = 1'b0;
    bit rx_hold_req   = 1'b0;
    bit rx_hold_taken = 1'b0;
    int rx_hold_left  = 0;

    epsilon_lexicase_pool_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // filters the pool with one case and returns the result it should produce
    function automatic elpf_result_t filter_case(elpf_item_t c);
        logic signed [FITNESS_WIDTH-1:0] fv [POOL_SIZE];
        longint       top;
        longint       mag;
        longint       thr;
        bit           seen_any;
        int           rank_seen;
        bit           picked;
        elpf_result_t r;
        fv[0] = c.fitness_0;
        fv[1] = c.fitness_1;
        fv[2] = c.fitness_2;
        fv[3] = c.fitness_3;
        fv[4] = c.fitness_4;
        if (c.first_case)
        begin
            pred_alive = FULL_MASK;
            pred_depth = 0;
        end
        if ($countones(pred_alive) > 1)
        begin
            seen_any = 1'b0;
            top = 0;
            for (int i = 0; i < POOL_SIZE; i++)
                if (pred_alive[i] && (!seen_any || longint'(fv[i]) > top))
                begin
                    top = fv[i];
                    seen_any = 1'b1;
                end
            mag = (top < 0) ? -top : top;
            // exact floor(|max| * eps / 2^16), split to keep the fraction bits
            thr = (mag >>> 16) * longint'(pred_eps)
                + (((mag & 64'hFFFF) * longint'(pred_eps)) >>> 16);
            for (int i = 0; i < POOL_SIZE; i++)
                if (pred_alive[i] && (top - longint'(fv[i])) > thr)
                    pred_alive[i] = 1'b0;
            if (pred_depth < CASE_LIMIT)
                pred_depth++;
        end
        r = '0;
        r.alive_slots    = pred_alive;
        r.survivor_count = COUNT_W'($countones(pred_alive));
        r.cases_used     = DEPTH_W'(pred_depth);
        if (c.last_case)
        begin
            r.choice_valid = 1'b1;
            rank_seen = 0;
            picked = 1'b0;
            // an oversized rank falls through to the highest alive slot
            for (int i = 0; i < POOL_SIZE; i++)
                if (pred_alive[i] && !picked)
                begin
                    r.chosen_slot = SLOT_W'(i);
                    if (rank_seen == int'(c.pick_rank))
                        picked = 1'b1;
                    rank_seen++;
                end
        end
        return r;
    endfunction

    function automatic elpf_item_t make_case(logic signed [31:0] f0, logic signed [31:0] f1,
                                             logic signed [31:0] f2, logic signed [31:0] f3,
                                             logic signed [31:0] f4, bit first, bit last,
                                             logic [2:0] rank);
        elpf_item_t c;
        c.fitness_0  = f0;
        c.fitness_1  = f1;
        c.fitness_2  = f2;
        c.fitness_3  = f3;
        c.fitness_4  = f4;
        c.first_case = first;
        c.last_case  = last;
        c.pick_rank  = rank;
        return c;
    endfunction

    function automatic void queue_case(elpf_item_t c);
        pending_cases = {pending_cases, c};
    endfunction

    // len cases forming one selection event; GEN_RAW sets first and last at random
    task automatic push_event(int len, gen_style_t style);
        logic signed [31:0] fv [POOL_SIZE];
        longint             top;
        longint             tol;
        longint             span;
        longint             v;
        int                 sh;
        bit                 first;
        bit                 last;
        for (int c = 0; c < len; c++)
        begin
            sh = $urandom_range(30);
            top = longint'($signed($urandom())) >>> (31 - sh);
            tol = (((top < 0) ? -top : top) * longint'(pred_eps)) >>> 16;
            span = 2 * tol + 4;
            if (span > longint'(32'hFFFF_FFFF))
                span = longint'(32'hFFFF_FFFF);
            for (int s = 0; s < POOL_SIZE; s++)
            begin
                case (style)
                    GEN_CLUSTER:
                    begin
                        // straddle the tolerance band around the case maximum
                        if ($urandom_range(3) == 0)
                            v = top;
                        else
                            v = top - longint'($urandom_range(32'(span)));
                        if (v < FIT_MIN)
                            v = FIT_MIN;
                        if (v > FIT_MAX)
                            v = FIT_MAX;
                        fv[s] = 32'(v);
                    end
                    GEN_TIES:
                        fv[s] = 32'(top);
                    default:
                        fv[s] = $urandom();
                endcase
            end
            first = (c == 0);
            last  = (c == len - 1);
            if (style == GEN_RAW)
            begin
                first = $urandom_range(1);
                last  = $urandom_range(1);
            end
            queue_case(make_case(fv[0], fv[1], fv[2], fv[3], fv[4],
                                 first, last, 3'($urandom_range(7))));
        end
    endtask

    task automatic fill_phase(int n_items);
        int added;
        int roll;
        int len;
        added = 0;
        while (added < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                // long tied events push the depth counter into saturation
                len = $urandom_range(20, 17);
                push_event(len, GEN_TIES);
            end
            else if (roll < 18)
            begin
                len = $urandom_range(3, 1);
                push_event(len, GEN_RAW);
            end
            else
            begin
                len = $urandom_range(8, 1);
                push_event(len, GEN_CLUSTER);
            end
            added += len;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (in_valid || pool_verdicts.size() != 0 || (pending_cases.size() != 0 && !send_hold));
    endtask

    task automatic write_eps(logic [EPS_WIDTH-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        pred_eps = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                pool_verdicts = {pool_verdicts, filter_case(in_item)};
            if (!in_valid || !in_stall)
            begin
                if (pending_cases.size() != 0 && !send_hold
                    && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_item  <= pending_cases.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and result stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pool_verdicts.size() == 0)
                begin
                    $error("result item with no case waiting for it");
                    errors++;
                end
                else
                begin
                    want = pool_verdicts.pop_front();
                    check_field("alive_slots", want.alive_slots, out_item.alive_slots);
                    check_field("survivor_count", want.survivor_count, out_item.survivor_count);
                    check_field("cases_used", want.cases_used, out_item.cases_used);
                    check_field("chosen_slot", want.chosen_slot, out_item.chosen_slot);
                    check_field("choice_valid", want.choice_valid, out_item.choice_valid);
                end
            end
            if (rx_hold_req && !rx_hold_taken)
            begin
                rx_hold_taken = 1'b1;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        logic [EPS_WIDTH-1:0] eps_plan [6];
        eps_plan = '{16'd0, 16'hFFFF, 16'h8000, 16'($urandom_range(65535)), 16'd1, EPS_RESET};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed cases at the reset tolerance
        queue_case(make_case(0, 0, 0, 0, 0, 1, 1, 0));
        queue_case(make_case(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                             32'sh7FFFFFFF, 32'sh7FFFFFFF, 1, 0, 0));
        queue_case(make_case(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                             32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 1, 7));
        queue_case(make_case(32'sh80000000, 32'sh80000000, 32'sh80000000,
                             32'sh80000000, 32'sh80000000, 1, 1, 2));
        queue_case(make_case(32'sh7FFFFFFF, 32'sh80000000, 0, -1, 1, 1, 0, 0));
        // single survivor: case is skipped, then the event runs on past its last case
        queue_case(make_case(5, -5, 32'sh80000000, 77, 32'sh7FFFFFFF, 0, 1, 3));
        queue_case(make_case(-9, 9, 0, 0, 1, 0, 0, 5));
        // exact edge of the band: max 10.0 gives a threshold of 65540
        queue_case(make_case(655360, 589820, 589819, 655360, 0, 1, 1, 2));
        queue_case(make_case(-655360, -720900, -720901, 32'sh80000000, -655360,
                             1, 1, 1));
        queue_case(make_case(1, 0, 0, 0, 0, 1, 1, 0));
        queue_case(make_case(5, 5, 5, 5, 5, 1, 1, 4));
        queue_case(make_case(5, 5, 5, 5, 5, 0, 1, 5));
        queue_case(make_case(5, 5, 5, 5, 5, 0, 1, 6));
        queue_case(make_case(3, 3, 2, 3, 3, 1, 1, 1));
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            write_eps(eps_plan[p]);
            quiet = (p == 2);
            fill_phase(PHASE_ITEMS);
            if (p == 1)
                rx_hold_req = 1'b1;
            if (p == 3)
            begin
                do
                    @(negedge clk);
                while (pending_cases.size() > PHASE_ITEMS / 2);
                send_hold = 1'b1;
                wait_drained();
                send_hold = 1'b0;
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pool_verdicts.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
